>>> hw/rtl/rgbconv_pkg.sv
// Shared types, constants and helpers for the RGB 3x3 convolution unit.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
package rgbconv_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Column index, effective width and row counter widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 2);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_W     = 11;
    localparam int MODE_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BOX     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EMBOSS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd4;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd480;

    // Pixel data
    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int LS_W   = 2 * PIX_W;
    localparam int CH_MAX = 255;

    // Kernel arithmetic: signed sum range -4096..4095 covers every kernel
    localparam int SUM_W       = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP9      = (2**RECIP_SHIFT + 9 - 1) / 9;
    localparam int RECIP_W     = 13;
    localparam int GAUSS_SHIFT = 4;

    // [2] red, [1] green, [0] blue
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pixel;
    // [0] upper row, [1] middle row, [2] current row
    typedef t_pixel [2:0] t_column;
    // [0] left column, [2] right column
    typedef t_column [2:0] t_window;

    // Border masks and frame marker travelling with an output position
    typedef struct packed {
        logic top_out;
        logic bot_out;
        logic left_out;
        logic right_out;
        logic last;
    } t_tap_ctrl;

    function automatic logic [W_W-1:0] eff_width(input logic [SIZE_W-1:0] v);
        logic [W_W-1:0] res;
        if (v == '0) begin
            res = W_W'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            res = W_W'(MAX_WIDTH);
        end else begin
            res = W_W'(v);
        end
        return res;
    endfunction

    function automatic logic [H_W-1:0] eff_height(input logic [SIZE_W-1:0] v);
        logic [H_W-1:0] res;
        if (v == '0) begin
            res = H_W'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            res = H_W'(MAX_HEIGHT);
        end else begin
            res = H_W'(v);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/rgbconv_in_if.sv
// Input channel: one pixel or flush request per handshake.
// Depends on rgbconv_pkg.
interface rgbconv_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [rgbconv_pkg::CH_W-1:0] red_in;
    logic [rgbconv_pkg::CH_W-1:0] green_in;
    logic [rgbconv_pkg::CH_W-1:0] blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

>>> hw/rtl/rgbconv_out_if.sv
// Output channel: one filtered pixel per handshake.
// Depends on rgbconv_pkg.
interface rgbconv_out_if;
    logic                         valid;
    logic                         ready;
    logic [rgbconv_pkg::CH_W-1:0] red_out;
    logic [rgbconv_pkg::CH_W-1:0] green_out;
    logic [rgbconv_pkg::CH_W-1:0] blue_out;
    logic                         last_of_frame;

    modport source (output valid, red_out, green_out, blue_out, last_of_frame, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

>>> hw/rtl/rgb_convolution_3x3_unit.sv
// RGB 3x3 convolution unit: top level, counters, line stores, window cells, kernel.
// Depends on rgbconv_pkg, rgbconv_in_if, rgbconv_out_if and the rgbconv_* modules.
// Throughput: one request per cycle unless a held output result stalls the pipe.
// An output position leaves one row plus one pixel behind the input; W+1 flushes drain a frame.
// Reset (synchronous, active low) clears counters, pipeline valids, and sets the registers to
// box blur, 640x480. Line stores are not cleared: unwritten entries are only read when masked.
module rgb_convolution_3x3_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgbconv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rgbconv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rgbconv_in_if.sink                          i_pix,
    rgbconv_out_if.source                       o_pix
);

    localparam int COL_W = rgbconv_pkg::COL_W;
    localparam int W_W   = rgbconv_pkg::W_W;
    localparam int H_W   = rgbconv_pkg::H_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rgbconv_pkg::MODE_W-1:0] r_kernel_mode;
    logic [rgbconv_pkg::SIZE_W-1:0] r_image_width;
    logic [rgbconv_pkg::SIZE_W-1:0] r_image_height;
    logic                           cfg_restart;

    logic [W_W-1:0] w;
    logic [H_W-1:0] h;

    assign w = rgbconv_pkg::eff_width(r_image_width);
    assign h = rgbconv_pkg::eff_height(r_image_height);

    // a size write restarts the frame; the mode takes effect at once
    assign cfg_restart = i_cfg_we && (i_cfg_idx == rgbconv_pkg::REG_IMAGE_WIDTH
                                   || i_cfg_idx == rgbconv_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode  <= rgbconv_pkg::MODE_BOX;
            r_image_width  <= rgbconv_pkg::RST_WIDTH;
            r_image_height <= rgbconv_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbconv_pkg::REG_KERNEL_MODE: begin
                    r_kernel_mode <= i_cfg_data[rgbconv_pkg::MODE_W-1:0];
                end
                rgbconv_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[rgbconv_pkg::SIZE_W-1:0];
                end
                rgbconv_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[rgbconv_pkg::SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe moves whenever the output register
    // is empty or being taken
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic adv;
    logic acc;

    assign adv         = !r_out_valid || o_pix.ready;
    assign acc         = i_pix.valid && adv;
    assign i_pix.ready = adv;

    // ------------------------------------------------------------------
    // Stage 0: position counters, request classification
    // ------------------------------------------------------------------
    logic [H_W-1:0]   r_in_row;
    logic [COL_W-1:0] r_in_col;
    logic [H_W-1:0]   r_out_row;
    logic [COL_W-1:0] r_out_col;
    logic [H_W-1:0]   n_in_row;
    logic [COL_W-1:0] n_in_col;
    logic [H_W-1:0]   n_out_row;
    logic [COL_W-1:0] n_out_col;

    logic             stale;
    logic [H_W-1:0]   ir;
    logic [COL_W-1:0] ic;
    logic [H_W-1:0]   orow;
    logic [COL_W-1:0] ocol;
    logic             in_frame;
    logic             active;
    logic             emit;
    logic [W_W-1:0]   in_col_inc;
    logic [W_W-1:0]   out_col_inc;
    logic             last;
    rgbconv_pkg::t_pixel     pix_in;
    rgbconv_pkg::t_tap_ctrl  ctrl_in;

    // counters left beyond the frame (never expected) start a new frame
    assign stale = (W_W'(r_in_col) >= w) || (r_in_row > (h + H_W'(1)));
    assign ir    = stale ? '0 : r_in_row;
    assign ic    = stale ? '0 : r_in_col;
    assign orow  = stale ? '0 : r_out_row;
    assign ocol  = stale ? '0 : r_out_col;

    // pixels are taken while rows are expected, flushes only afterwards
    assign in_frame = ir < h;
    assign active   = in_frame ? !i_pix.kind : i_pix.kind;

    // wrap to column zero completes the previous row's last position
    assign emit = active && (((ic == '0) && (ir >= H_W'(2)))
                          || ((ic != '0) && (ir >= H_W'(1))));

    assign in_col_inc  = W_W'(ic) + W_W'(1);
    assign out_col_inc = W_W'(ocol) + W_W'(1);
    assign last        = (orow == h - H_W'(1)) && (W_W'(ocol) == w - W_W'(1));

    assign pix_in = in_frame ? {i_pix.red_in, i_pix.green_in, i_pix.blue_in} : '0;

    assign ctrl_in.top_out   = (orow == '0);
    assign ctrl_in.bot_out   = ((orow + H_W'(1)) >= h);
    assign ctrl_in.left_out  = (ocol == '0);
    assign ctrl_in.right_out = (out_col_inc >= w);
    assign ctrl_in.last      = last;

    always_comb begin
        n_in_row  = ir;
        n_in_col  = ic;
        n_out_row = orow;
        n_out_col = ocol;
        if (active) begin
            if (in_col_inc >= w) begin
                n_in_col = '0;
                n_in_row = ir + H_W'(1);
            end else begin
                n_in_col = in_col_inc[COL_W-1:0];
            end
        end
        if (emit) begin
            priority if (last) begin
                // frame done: next pixel opens a new frame
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else if (out_col_inc >= w) begin
                n_out_col = '0;
                n_out_row = orow + H_W'(1);
            end else begin
                n_out_col = out_col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (cfg_restart) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (acc) begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read data arrives; write back and shift window
    // ------------------------------------------------------------------
    logic                    r_s1_valid;
    logic                    r_s1_emit;
    logic [COL_W-1:0]        r_s1_addr;
    rgbconv_pkg::t_pixel     r_s1_pix;
    rgbconv_pkg::t_tap_ctrl  r_s1_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= acc && active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_emit <= emit;
            r_s1_addr <= ic;
            r_s1_pix  <= pix_in;
            r_s1_ctrl <= ctrl_in;
        end
    end

    logic [rgbconv_pkg::LS_W-1:0] ls_rd_data;
    rgbconv_pkg::t_pixel          col_upper;
    rgbconv_pkg::t_pixel          col_middle;
    logic                         shift;

    assign shift      = adv && r_s1_valid;
    assign col_upper  = ls_rd_data[rgbconv_pkg::LS_W-1:rgbconv_pkg::PIX_W];
    assign col_middle = ls_rd_data[rgbconv_pkg::PIX_W-1:0];

    // middle moves up to upper, the new pixel becomes middle
    rgbconv_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_rd_addr (ic),
        .i_wr_en   (shift),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({col_middle, r_s1_pix}),
        .o_rd_data (ls_rd_data)
    );

    // Window: three column cells, new column enters on the right
    rgbconv_pkg::t_column  col_new;
    rgbconv_pkg::t_window  win;

    assign col_new[0] = col_upper;
    assign col_new[1] = col_middle;
    assign col_new[2] = r_s1_pix;

    rgbconv_column_cell u_cell_right (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_col   (col_new),
        .o_col   (win[2])
    );

    rgbconv_column_cell u_cell_centre (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_col   (win[2]),
        .o_col   (win[1])
    );

    rgbconv_column_cell u_cell_left (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_col   (win[1]),
        .o_col   (win[0])
    );

    // ------------------------------------------------------------------
    // Stage 2: window complete; kernel sums, stage 3 scale and clamp
    // ------------------------------------------------------------------
    logic                    r_s2_valid;
    rgbconv_pkg::t_tap_ctrl  r_s2_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    logic                 k_valid;
    logic                 k_last;
    rgbconv_pkg::t_pixel  k_rgb;

    rgbconv_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s2_valid),
        .i_ctrl  (r_s2_ctrl),
        .i_win   (win),
        .i_mode  (r_kernel_mode),
        .o_valid (k_valid),
        .o_last  (k_last),
        .o_rgb   (k_rgb)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    rgbconv_pkg::t_pixel r_out_rgb;
    logic                r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= k_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && k_valid) begin
            r_out_rgb  <= k_rgb;
            r_out_last <= k_last;
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.red_out       = r_out_rgb[2];
    assign o_pix.green_out     = r_out_rgb[1];
    assign o_pix.blue_out      = r_out_rgb[0];
    assign o_pix.last_of_frame = r_out_last;

endmodule

>>> hw/rtl/rgbconv_line_store.sv
// Paired line stores (upper and middle row) in one memory word per column.
// Registered read with forwarding of a write to the address being read.
// Depends on rgbconv_pkg.
module rgbconv_line_store (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [rgbconv_pkg::COL_W-1:0]  i_rd_addr,
    input  logic                           i_wr_en,
    input  logic [rgbconv_pkg::COL_W-1:0]  i_wr_addr,
    input  logic [rgbconv_pkg::LS_W-1:0]   i_wr_data,
    output logic [rgbconv_pkg::LS_W-1:0]   o_rd_data
);

    logic [rgbconv_pkg::LS_W-1:0] r_mem [rgbconv_pkg::MAX_WIDTH];
    logic [rgbconv_pkg::LS_W-1:0] r_rd_data;
    logic [rgbconv_pkg::LS_W-1:0] r_fwd_data;
    logic                         r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // one-column rows read the entry written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

>>> hw/rtl/rgbconv_column_cell.sv
// One column of the 3x3 window; cells are chained right to left.
// Depends on rgbconv_pkg.
module rgbconv_column_cell (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  rgbconv_pkg::t_column i_col,
    output rgbconv_pkg::t_column o_col
);

    rgbconv_pkg::t_column r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

>>> hw/rtl/rgbconv_kernel.sv
// Kernel arithmetic: masked weighted sums (registered), then scale and clamp.
// Depends on rgbconv_pkg.
module rgbconv_kernel (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  rgbconv_pkg::t_tap_ctrl                i_ctrl,
    input  rgbconv_pkg::t_window                  i_win,
    input  logic [rgbconv_pkg::MODE_W-1:0]        i_mode,
    output logic                                  o_valid,
    output logic                                  o_last,
    output rgbconv_pkg::t_pixel                   o_rgb
);

    localparam int SUM_W = rgbconv_pkg::SUM_W;
    localparam int PROD_W = SUM_W + rgbconv_pkg::RECIP_W;

    logic                      tap_en [3][3];
    logic [rgbconv_pkg::CH_W-1:0] v   [rgbconv_pkg::NUM_CH][3][3];
    logic signed [SUM_W-1:0]   s   [rgbconv_pkg::NUM_CH][3][3];
    logic signed [SUM_W-1:0]   sc  [rgbconv_pkg::NUM_CH];
    logic signed [SUM_W-1:0]   se  [rgbconv_pkg::NUM_CH];
    logic signed [SUM_W-1:0]   n_sum [rgbconv_pkg::NUM_CH];
    logic signed [SUM_W-1:0]   r_sum [rgbconv_pkg::NUM_CH];
    logic [PROD_W-1:0]         prod  [rgbconv_pkg::NUM_CH];
    logic signed [SUM_W-1:0]   q     [rgbconv_pkg::NUM_CH];
    logic                      r_valid;
    logic                      r_last;

    // Neighbours outside the frame read as zero
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                tap_en[r][c] = !((r == 0 && i_ctrl.top_out) || (r == 2 && i_ctrl.bot_out)
                              || (c == 0 && i_ctrl.left_out) || (c == 2 && i_ctrl.right_out));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < rgbconv_pkg::NUM_CH; k++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    v[k][r][c] = tap_en[r][c] ? i_win[c][r][k] : '0;
                    s[k][r][c] = signed'(SUM_W'(v[k][r][c]));
                end
            end
            sc[k] = s[k][0][0] + s[k][0][2] + s[k][2][0] + s[k][2][2];
            se[k] = s[k][0][1] + s[k][1][0] + s[k][1][2] + s[k][2][1];
            unique case (i_mode)
                rgbconv_pkg::MODE_GAUSS: begin
                    n_sum[k] = sc[k] + (se[k] <<< 1) + (s[k][1][1] <<< 2);
                end
                rgbconv_pkg::MODE_OUTLINE: begin
                    n_sum[k] = (s[k][1][1] <<< 3) - sc[k] - se[k];
                end
                rgbconv_pkg::MODE_EMBOSS: begin
                    n_sum[k] = s[k][1][1] + s[k][1][2] + s[k][2][1] + (s[k][2][2] <<< 1)
                             - (s[k][0][0] <<< 1) - s[k][0][1] - s[k][1][0];
                end
                rgbconv_pkg::MODE_SHARPEN: begin
                    n_sum[k] = (s[k][1][1] <<< 2) + s[k][1][1] - se[k];
                end
                default: begin
                    // box blur, also for the unused codes
                    n_sum[k] = sc[k] + se[k] + s[k][1][1];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_sum  <= n_sum;
            r_last <= i_ctrl.last;
        end
    end

    // Scale and clamp; floor(sum/9) via reciprocal, exact for sums below 2^15
    always_comb begin
        for (int k = 0; k < rgbconv_pkg::NUM_CH; k++) begin
            prod[k] = PROD_W'(unsigned'(r_sum[k])) * PROD_W'(rgbconv_pkg::RECIP9);
            unique case (i_mode)
                rgbconv_pkg::MODE_GAUSS: begin
                    q[k] = r_sum[k] >>> rgbconv_pkg::GAUSS_SHIFT;
                end
                rgbconv_pkg::MODE_OUTLINE, rgbconv_pkg::MODE_EMBOSS,
                rgbconv_pkg::MODE_SHARPEN: begin
                    q[k] = r_sum[k];
                end
                default: begin
                    q[k] = signed'(SUM_W'(prod[k] >> rgbconv_pkg::RECIP_SHIFT));
                end
            endcase
            if (r_sum[k] < 0) begin
                o_rgb[k] = '0;
            end else if (q[k] > SUM_W'(rgbconv_pkg::CH_MAX)) begin
                o_rgb[k] = rgbconv_pkg::CH_W'(rgbconv_pkg::CH_MAX);
            end else begin
                o_rgb[k] = q[k][rgbconv_pkg::CH_W-1:0];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;

endmodule

>>> hw/rtl/rgbconv_checker.sv
// Port-level checks for the RGB 3x3 convolution unit, bound to its top level.
// Depends on rgb_convolution_3x3_unit and its interfaces.
module rgbconv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [24:0] i_out_data
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input stalls only behind a held result
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track output register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

endmodule

bind rgb_convolution_3x3_unit rgbconv_checker u_rgbconv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  ({o_pix.red_out, o_pix.green_out, o_pix.blue_out, o_pix.last_of_frame})
);

>>> sim/tb_rgb_convolution_3x3_unit.sv
// Self-checking testbench for the RGB 3x3 convolution unit: directed and random frames,
// random back-pressure, a long output stall and a request-level window predictor.
// Depends on rgbconv_pkg, rgbconv_in_if, rgbconv_out_if and rgb_convolution_3x3_unit.
module tb_rgb_convolution_3x3_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbconv_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int IDLE_PCT        = 9;     // chance per cycle of an idle on either side
    localparam int RANDOM_REQUESTS = 300;   // requests the block absorbs in the random part
    localparam int DRAIN_CYCLES    = 8;     // covers the stage 1, stage 2, kernel and output registers, with margin
    localparam int TAIL_CYCLES     = 10;
    localparam int HOLD_CYCLES     = 300;   // one long output stall to back the block up
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;

    // Request kinds on the input channel
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        t_pixel colour;
        logic   last;
    } t_filtered;

    // Tracks the frame position, line stores and window exactly as the block should,
    // and keeps the filtered pixels still owed by the block, oldest first.
    class convolution_scoreboard;
        t_pixel            upper_row [MAX_WIDTH];
        t_pixel            middle_row [MAX_WIDTH];
        t_pixel            win [3][3];          // [row][column], row 0 on top
        int                in_row, in_col, out_row, out_col;
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] width_reg, height_reg;
        t_filtered         expected_pixels [$];
        int                absorbed, ignored, checked, mismatches, frames_done;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            mode       = MODE_BOX;
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            restart();
        endfunction

        function void restart();
            foreach (win[r, c]) win[r][c] = '0;
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        // Zero acts as one, anything past the maximum as the maximum
        function int width_eff();
            if (width_reg == '0) return 1;
            return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        endfunction

        function int height_eff();
            if (height_reg == '0) return 1;
            return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        endfunction

        function bit in_tail();
            return in_row >= height_eff();
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KERNEL_MODE: begin
                    mode = data[MODE_W-1:0];
                end
                REG_IMAGE_WIDTH: begin
                    width_reg = data;
                    restart();
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg = data;
                    restart();
                end
                default: ;
            endcase
        endfunction

        function int kernel_tap(logic [MODE_W-1:0] m, int r, int c);
            bit mid_r, mid_c;
            mid_r = (r == 1);
            mid_c = (c == 1);
            case (m)
                MODE_GAUSS:   return (mid_r ? 2 : 1) * (mid_c ? 2 : 1);
                MODE_OUTLINE: return (mid_r && mid_c) ? 8 : -1;
                MODE_EMBOSS:  return (mid_r && mid_c) ? 1 : r + c - 2;
                MODE_SHARPEN: return (mid_r && mid_c) ? 5 : ((mid_r != mid_c) ? -1 : 0);
                default:      return 1;     // box blur, also taken by the unused codes
            endcase
        endfunction

        function t_pixel filter_window(t_pixel taps [3][3], int orow, int ocol, int w, int h);
            int     acc [3];
            int     row, col, s;
            t_pixel res;
            acc = '{0, 0, 0};
            for (int r = 0; r < 3; r++) begin
                row = orow - 1 + r;
                for (int c = 0; c < 3; c++) begin
                    col = ocol - 1 + c;
                    if (row >= 0 && row < h && col >= 0 && col < w) begin
                        for (int ch = 0; ch < NUM_CH; ch++)
                            acc[ch] += int'(taps[r][c][ch]) * kernel_tap(mode, r, c);
                    end
                end
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                s = acc[ch];
                if (mode == MODE_BOX || mode > MODE_SHARPEN) begin
                    s = (s < 0) ? 0 : s / 9;
                end else if (mode == MODE_GAUSS) begin
                    s = (s < 0) ? 0 : s / 16;
                end
                res[ch] = (s < 0) ? 8'd0 : (s > CH_MAX) ? 8'd255 : 8'(s);
            end
            return res;
        endfunction

        // Advance the model by one accepted request; queue the pixel it releases, if any
        function void note_request(logic kind, t_pixel px_in);
            int        w, h, ir, ic;
            t_pixel    px, col_u, col_m;
            t_pixel    taps [3][3];
            bit        emit, last;
            t_filtered res;
            w = width_eff();
            h = height_eff();
            if (in_col >= w || in_row > h + 1) restart();
            ir = in_row;
            ic = in_col;
            if (ir < h) begin
                if (kind == KIND_FLUSH) begin
                    ignored++;
                    return;
                end
                px = px_in;
            end else begin
                if (kind == KIND_PIXEL) begin
                    ignored++;
                    return;
                end
                px = '0;
            end
            absorbed++;

            col_u          = upper_row[ic];
            col_m          = middle_row[ic];
            upper_row[ic]  = col_m;
            middle_row[ic] = px;

            emit = 1'b0;
            // Start of a new row closes the last column of the row above
            if (ic == 0 && ir >= 2) begin
                for (int r = 0; r < 3; r++) begin
                    taps[r][0] = win[r][1];
                    taps[r][1] = win[r][2];
                    taps[r][2] = '0;
                end
                emit = 1'b1;
            end
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = col_u;
            win[1][2] = col_m;
            win[2][2] = px;
            if (ic >= 1 && ir >= 1) begin
                taps = win;
                emit = 1'b1;
            end

            in_col = ic + 1;
            if (in_col >= w) begin
                in_col = 0;
                in_row = ir + 1;
            end
            if (!emit) return;

            last       = (out_row == h - 1) && (out_col == w - 1);
            res.colour = filter_window(taps, out_row, out_col, w, h);
            res.last   = last;
            expected_pixels.push_back(res);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
            if (last) begin
                restart();
                frames_done++;
            end
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] seen);
            if (seen !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result %0d: %s expected %0h, got %0h",
                             $time, checked, field, want, seen);
            end
        endfunction

        function void check_result(t_filtered seen);
            t_filtered want;
            checked++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] result %0d arrived with nothing outstanding: %0h",
                             $time, checked, seen);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red", want.colour[2], seen.colour[2]);
            compare_field("green", want.colour[1], seen.colour[1]);
            compare_field("blue", want.colour[0], seen.colour[0]);
            compare_field("last_of_frame", want.last, seen.last);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rgbconv_in_if  pix_in ();
    rgbconv_out_if pix_out ();

    rgb_convolution_3x3_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    convolution_scoreboard sb;

    bit steady;         // set: neither side idles (a long stretch at full rate)
    bit stall_armed;    // set: the receiver takes its long hold-off at the next result
    int requests_sent;
    int cfg_writes;

    always #CLK_HALF i_clk = ~i_clk;

    // -------------------------------------------------------------------------
    // Pixel and configuration drivers
    // -------------------------------------------------------------------------

    // style 0: uniform noise; 1: channels at either rail; 2: mid-grey values in 120..135
    function automatic t_pixel rand_pixel(input int style);
        t_pixel p;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            case (style)
                0:       p[ch] = 8'($urandom);
                1:       p[ch] = $urandom_range(1) ? 8'hFF : 8'h00;
                default: p[ch] = 8'(120 + $urandom_range(15));
            endcase
        end
        return p;
    endfunction

    // Kernel codes 5..7 included; the bits above the mode field carry rubbish
    function automatic logic [CFG_DATA_W-1:0] random_mode_word();
        return {8'($urandom), 3'($urandom_range(7))};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return '0;                 // treated as one
            1:       return CFG_DATA_W'(1);
            default: return CFG_DATA_W'($urandom_range(2, 9));
        endcase
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_request(input logic kind, input t_pixel px);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.kind     <= kind;
        pix_in.red_in   <= px[2];
        pix_in.green_in <= px[1];
        pix_in.blue_in  <= px[0];
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        sb.note_request(kind, px);
        requests_sent++;
    endtask

    // Stop offering, collect everything owed, then give the pipeline time to settle
    // (a request that releases no pixel may still be inside it)
    task automatic drain();
        pix_in.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    // Only called with the block idle; the enable drops once after the last write
    task automatic configure(input bit set_mode, input logic [CFG_DATA_W-1:0] mode_word,
                             input bit set_w, input logic [CFG_DATA_W-1:0] w_word,
                             input bit set_h, input logic [CFG_DATA_W-1:0] h_word);
        if (set_mode) write_reg(REG_KERNEL_MODE, mode_word);
        if (set_w) write_reg(REG_IMAGE_WIDTH, w_word);
        if (set_h) write_reg(REG_IMAGE_HEIGHT, h_word);
        i_cfg_we <= 1'b0;
    endtask

    // One frame: pixels until the tail, then flushes until the corner pixel is out.
    // pause_at switches the kernel mid-frame, stop_at abandons the frame; -1 for neither.
    // noise_pct sprinkles in requests that the block must ignore.
    task automatic run_frame(input int style, input int pause_at, input int stop_at,
                             input int noise_pct);
        int sent;
        sent = 0;
        while (!sb.in_tail()) begin
            if (sent == stop_at) return;
            if (sent == pause_at) begin
                drain();
                configure(1'b1, random_mode_word(), 1'b0, '0, 1'b0, '0);
            end
            if ($urandom_range(99) < noise_pct) send_request(KIND_FLUSH, rand_pixel(0));
            send_request(KIND_PIXEL, rand_pixel(style));
            sent++;
        end
        while (sb.in_tail()) begin
            if ($urandom_range(99) < noise_pct) send_request(KIND_PIXEL, rand_pixel(0));
            send_request(KIND_FLUSH, rand_pixel(0));
        end
    endtask

    // -------------------------------------------------------------------------
    // Receiver: checks each filtered pixel, then decides ready for the next edge.
    // Random idling as on the input, none while steady, plus one long hold-off
    // so that the block fills up and pushes back on its input.
    // -------------------------------------------------------------------------
    initial begin
        t_filtered seen;
        int        hold_left;
        hold_left     = 0;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
                seen.colour = {pix_out.red_out, pix_out.green_out, pix_out.blue_out};
                seen.last   = pix_out.last_of_frame;
                sb.check_result(seen);
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end else if (stall_armed && pix_out.valid === 1'b1) begin
                stall_armed   = 1'b0;
                hold_left     = HOLD_CYCLES;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // -------------------------------------------------------------------------
    // Watchdog: gives up after too many cycles with no request moving either way
    // -------------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
                (pix_out.valid === 1'b1 && pix_out.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] watchdog: no request moved for %0d cycles, %0d pixels outstanding",
                 $time, WATCHDOG_LIMIT, sb.pending());
        $display("rgb_convolution_3x3_unit verification failed");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------
    initial begin
        int   base, frames;
        int   pause_at, stop_at;
        bit   set_w, set_h;
        int   pick;
        sb = new();
        steady      = 1'b0;
        stall_armed = 1'b0;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        pix_in.valid    <= 1'b0;
        pix_in.kind     <= KIND_PIXEL;
        pix_in.red_in   <= '0;
        pix_in.green_in <= '0;
        pix_in.blue_in  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (box blur, 640 wide): a row and a bit, enough to see the
        // start of the first row of output; the frame is then abandoned by the size writes below
        for (int n = 0; n < 645; n++) send_request(KIND_PIXEL, rand_pixel(0));
        drain();

        // Directed: 4x3 outline on a rail-to-rail pattern, so results clamp at both rails.
        // A flush before the first pixel and a pixel past the end are both ignored; W+1 flushes
        // drain the tail, and one more finds nothing pending.
        configure(1'b1, CFG_DATA_W'(MODE_OUTLINE), 1'b1, CFG_DATA_W'(4), 1'b1, CFG_DATA_W'(3));
        send_request(KIND_FLUSH, 24'hFFFFFF);
        for (int n = 0; n < 12; n++) begin
            case (n % 4)
                0: send_request(KIND_PIXEL, 24'h000000);
                1: send_request(KIND_PIXEL, 24'hFFFFFF);
                2: send_request(KIND_PIXEL, 24'hAA55AA);
                default: send_request(KIND_PIXEL, 24'h55AA55);
            endcase
        end
        send_request(KIND_PIXEL, 24'hFFFFFF);
        for (int n = 0; n < 5; n++) send_request(KIND_FLUSH, 24'h000000);
        send_request(KIND_FLUSH, 24'h000000);
        drain();

        // A 32x3 frame at full rate, with the long output hold-off landing once
        // results start to flow
        steady = 1'b1;
        configure(1'b1, CFG_DATA_W'(MODE_SHARPEN), 1'b1, CFG_DATA_W'(32),
                  1'b1, CFG_DATA_W'(3));
        stall_armed = 1'b1;
        run_frame(0, -1, -1, 0);
        steady = 1'b0;
        drain();

        // Tallest frame, one column: zero width acts as one, height clips to the maximum
        configure(1'b1, CFG_DATA_W'(MODE_EMBOSS), 1'b1, '0, 1'b1, CFG_DATA_W'(2047));
        run_frame(1, -1, -1, 2);
        drain();

        // Random phases: new sizes (always at least one, which restarts the frame),
        // usually a new kernel, then a few frames with random content.  Now and then
        // the kernel changes mid-frame, or the last frame is abandoned.
        base = sb.absorbed;
        while (sb.absorbed - base < RANDOM_REQUESTS) begin
            pick  = $urandom_range(9);
            set_w = (pick < 8);
            set_h = (pick >= 2);
            configure($urandom_range(9) < 7, random_mode_word(),
                      set_w, pick_size(), set_h, pick_size());
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                pause_at = ($urandom_range(99) < 15) ? $urandom_range(0, 20) : -1;
                stop_at  = (f == frames - 1 && $urandom_range(99) < 10) ?
                           $urandom_range(0, 20) : -1;
                run_frame($urandom_range(2), pause_at, stop_at, 3);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (%0d ignored by the block), %0d register writes;",
                 requests_sent, sb.ignored, cfg_writes);
        $display("checked %0d filtered pixels over %0d complete frames, %0d mismatches.",
                 sb.checked, sb.frames_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("rgb_convolution_3x3_unit verification clean");
        end else begin
            $display("rgb_convolution_3x3_unit verification failed");
        end
        $finish;
    end

endmodule
